FILE: hw/rtl/flvp_pkg.sv
// Shared constants, types and helpers for the FLV tag stream parser.
package flvp_pkg;

  // Parser phases
  localparam logic [3:0] PH_SIG    = 4'd0;
  localparam logic [3:0] PH_VER    = 4'd1;
  localparam logic [3:0] PH_FLAGS  = 4'd2;
  localparam logic [3:0] PH_HSIZE  = 4'd3;
  localparam logic [3:0] PH_HEXTRA = 4'd4;
  localparam logic [3:0] PH_PREV   = 4'd5;
  localparam logic [3:0] PH_THDR   = 4'd6;
  localparam logic [3:0] PH_BODY   = 4'd7;
  localparam logic [3:0] PH_DEAD   = 4'd8;

  // Report status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_STREAM_ID = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_MEDIA = 3'd4;
  localparam logic [2:0] ST_BAD_PKT   = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;

  // Report kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_TAG    = 1'b1;

  // Tag types
  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;

  // Media codes
  localparam logic [3:0] AUDIO_AAC  = 4'd10;
  localparam logic [3:0] VIDEO_AVC  = 4'd7;

  // File header constants
  localparam logic [7:0] FLV_VERSION    = 8'h01;
  localparam logic [7:0] FLAGS_RSVD     = 8'hfa;
  localparam logic [31:0] HDR_BASE_SIZE = 32'd9;

  localparam int TDATA_W = 144;

  // Body-derived part of a tag report
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  media_header;
    logic [7:0]  packet_type;
    logic [23:0] composition_offset;
  } tag_fields_t;

  // Signature bytes "FLV"
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    sig_byte = 8'h46;
      2'd1:    sig_byte = 8'h4c;
      2'd2:    sig_byte = 8'h56;
      default: sig_byte = 8'h00;
    endcase
  endfunction

endpackage

FILE: hw/rtl/flvp_tag_eval.sv
// Status decision and body-derived fields of one tag report.
module flvp_tag_eval
  import flvp_pkg::*;
(
  input  logic [7:0]  ttype,
  input  logic [23:0] stream_id,
  input  logic [7:0]  media,
  input  logic [7:0]  packet,
  input  logic [23:0] offset,
  input  logic [23:0] got,
  input  logic        complete,
  output tag_fields_t fields
);

  logic [3:0] hi;
  logic [3:0] lo;
  logic [2:0] ok_or_trunc;
  logic [2:0] short_st;

  assign hi = media[7:4];
  assign lo = media[3:0];
  assign ok_or_trunc = complete ? ST_OK : ST_TRUNC;
  assign short_st    = complete ? ST_BAD_PKT : ST_TRUNC;

  // Order: stream id, type, media header, packet type; each needs its bytes first
  always_comb begin
    fields = '0;
    if (stream_id != 24'd0) begin
      fields.status = ST_STREAM_ID;
    end else if (!(ttype inside {TAG_AUDIO, TAG_VIDEO, TAG_SCRIPT})) begin
      fields.status = ST_BAD_TYPE;
    end else if (ttype == TAG_SCRIPT) begin
      fields.status = ok_or_trunc;
    end else if (got == 24'd0) begin
      fields.status = complete ? ST_BAD_MEDIA : ST_TRUNC;
    end else if (ttype == TAG_AUDIO) begin
      fields.media_header = media;
      if (hi inside {4'd12, 4'd13}) begin
        fields.status = ST_BAD_MEDIA;
      end else if (hi != AUDIO_AAC) begin
        fields.status = ok_or_trunc;
      end else if (got < 24'd2) begin
        fields.status = short_st;
      end else begin
        fields.packet_type = packet;
        if (packet > 8'd1) begin
          fields.status = ST_BAD_PKT;
        end else if (packet == 8'd0 && got < 24'd4) begin
          fields.status = short_st;
        end else begin
          fields.status = ok_or_trunc;
        end
      end
    end else begin
      fields.media_header = media;
      if (!(hi inside {[4'd1:4'd5]}) || !(lo inside {[4'd1:4'd7]})) begin
        fields.status = ST_BAD_MEDIA;
      end else if (lo != VIDEO_AVC) begin
        fields.status = ok_or_trunc;
      end else if (got < 24'd2) begin
        fields.status = short_st;
      end else begin
        fields.packet_type = packet;
        if (packet > 8'd2) begin
          fields.status = ST_BAD_PKT;
        end else if (got < 24'd5) begin
          fields.status = short_st;
        end else begin
          fields.composition_offset = offset;
          fields.status = ok_or_trunc;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/flv_tag_stream_parser_core.sv
// Top level of the FLV tag stream parser: byte walker and report register.
//
// Usage: feed the FLV file one byte per item on the s_ channel, with s_tlast
// on the final byte. One report leaves on m_ for the file header (on its ninth
// byte, the first byte that breaks it, or a final byte inside it) and one per
// tag (on its last body byte, last tag header byte for an empty body, or a final byte after its header).
// m_tuser tells a header report from a tag report.
// A report is registered: it is valid on m_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the per-byte phase and
// counter update plus the tag status decision sit between the parser state
// and the report register.
// Stall: s_tready falls only while a report is held and m_tready is low.
// Reset (rst, synchronous) and the final byte of a stream both return the
// parser to the start of a new file header; a bad header makes the parser
// drop bytes until the final byte.
module flv_tag_stream_parser_core
  import flvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte[7:0]
  input  logic               s_tlast,   // end_of_stream
  output logic               m_tvalid,
  input  logic               m_tready,
  // status[2:0], has_audio[3], has_video[4], rec_type[12:5], data_size[36:13],
  // timestamp[68:37], prev_tag_size[100:69], media_header[108:101],
  // packet_type[116:109], composition_offset[140:117], zero fill[143:141]
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser    // result_kind
);

  // Parser state
  logic [3:0]  phase, phase_next;
  logic [23:0] cnt, cnt_next;
  logic [31:0] hextra, hextra_next;
  logic [31:0] prev, prev_next;
  logic [7:0]  ttype, ttype_next;
  logic [23:0] blen, blen_next;
  logic [31:0] tstamp, tstamp_next;
  logic [23:0] sid, sid_next;
  logic [7:0]  media, media_next;
  logic [7:0]  pkt, pkt_next;
  logic [23:0] off, off_next;
  logic        aflag, aflag_next;
  logic        vflag, vflag_next;

  logic        acc;
  logic        bad;
  logic        emit_hdr;
  logic        emit_tag;
  logic        complete;
  logic [2:0]  hdr_st;
  logic [23:0] cnt_inc;
  logic [23:0] got;
  logic [31:0] hx;
  tag_fields_t tf;
  logic [TDATA_W-1:0] tdata_next;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign cnt_inc  = cnt + 24'd1;
  assign hx       = {hextra[23:0], s_tdata};
  // bytes of body seen, as the tag evaluation needs it
  assign got      = (phase == PH_BODY) ? cnt_inc : 24'd0;

  // Next state for one byte
  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    hextra_next = hextra;
    prev_next   = prev;
    ttype_next  = ttype;
    blen_next   = blen;
    tstamp_next = tstamp;
    sid_next    = sid;
    media_next  = media;
    pkt_next    = pkt;
    off_next    = off;
    aflag_next  = aflag;
    vflag_next  = vflag;
    bad         = 1'b0;
    emit_hdr    = 1'b0;
    emit_tag    = 1'b0;
    complete    = 1'b1;
    hdr_st      = ST_OK;
    case (phase)
      PH_SIG: begin
        if (cnt < 24'd3 && s_tdata == sig_byte(cnt[1:0])) begin
          cnt_next = cnt_inc;
          if (cnt == 24'd2) begin
            phase_next = PH_VER;
            cnt_next   = 24'd0;
          end
        end else begin
          bad = 1'b1;
        end
      end
      PH_VER: begin
        if (s_tdata == FLV_VERSION) phase_next = PH_FLAGS;
        else bad = 1'b1;
      end
      PH_FLAGS: begin
        if ((s_tdata & FLAGS_RSVD) != 8'd0) begin
          bad = 1'b1;
        end else begin
          aflag_next  = s_tdata[2];
          vflag_next  = s_tdata[0];
          phase_next  = PH_HSIZE;
          cnt_next    = 24'd0;
          hextra_next = 32'd0;
        end
      end
      PH_HSIZE: begin
        hextra_next = hx;
        cnt_next    = cnt_inc;
        if (cnt == 24'd3) begin
          emit_hdr    = 1'b1;
          hextra_next = (hx > HDR_BASE_SIZE) ? hx - HDR_BASE_SIZE : 32'd0;
          phase_next  = (hx > HDR_BASE_SIZE) ? PH_HEXTRA : PH_PREV;
          cnt_next    = 24'd0;
        end
      end
      PH_HEXTRA: begin
        hextra_next = hextra - 32'd1;
        if (hextra == 32'd1) begin
          phase_next = PH_PREV;
          cnt_next   = 24'd0;
        end
      end
      PH_PREV: begin
        prev_next = {prev[23:0], s_tdata};
        cnt_next  = cnt_inc;
        if (cnt == 24'd3) begin
          phase_next = PH_THDR;
          cnt_next   = 24'd0;
        end
      end
      PH_THDR: begin
        case (cnt[3:0])
          4'd0: begin
            ttype_next  = s_tdata;
            blen_next   = 24'd0;
            tstamp_next = 32'd0;
            sid_next    = 24'd0;
            media_next  = 8'd0;
            pkt_next    = 8'd0;
            off_next    = 24'd0;
          end
          4'd1, 4'd2, 4'd3: blen_next   = {blen[15:0], s_tdata};
          4'd4, 4'd5, 4'd6: tstamp_next = {8'd0, tstamp[15:0], s_tdata};
          4'd7:             tstamp_next = {s_tdata, tstamp[23:0]};
          default:          sid_next    = {sid[15:0], s_tdata};
        endcase
        cnt_next = cnt_inc;
        if (cnt == 24'd10) begin
          cnt_next = 24'd0;
          if (blen_next == 24'd0) begin
            emit_tag   = 1'b1;
            phase_next = PH_PREV;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (cnt == 24'd0) media_next = s_tdata;
        else if (cnt == 24'd1) pkt_next = s_tdata;
        else if (cnt <= 24'd4) off_next = {off[15:0], s_tdata};
        cnt_next = cnt_inc;
        if (cnt_inc >= blen) begin
          emit_tag   = 1'b1;
          phase_next = PH_PREV;
          cnt_next   = 24'd0;
        end
      end
      default: begin
      end
    endcase

    // broken file header: report once, then drop bytes
    if (bad) begin
      emit_hdr   = 1'b1;
      hdr_st     = ST_BAD_HDR;
      aflag_next = 1'b0;
      vflag_next = 1'b0;
      phase_next = PH_DEAD;
      cnt_next   = 24'd0;
    end

    // final byte with nothing reported yet
    if (s_tlast && !emit_hdr && !emit_tag) begin
      if (phase_next <= PH_HSIZE) begin
        emit_hdr = 1'b1;
        hdr_st   = ST_BAD_HDR;
      end else if (phase_next == PH_BODY) begin
        emit_tag = 1'b1;
        complete = 1'b0;
      end
    end
  end

  flvp_tag_eval u_eval (
    .ttype    (ttype_next),
    .stream_id(sid_next),
    .media    (media_next),
    .packet   (pkt_next),
    .offset   (off_next),
    .got      (got),
    .complete (complete),
    .fields   (tf)
  );

  // Report payload
  always_comb begin
    if (emit_tag) begin
      tdata_next = {3'd0, tf.composition_offset, tf.packet_type, tf.media_header,
                    prev_next, tstamp_next, blen_next, ttype_next,
                    vflag, aflag, tf.status};
    end else begin
      tdata_next = '0;
      tdata_next[2:0] = hdr_st;
      tdata_next[3]   = (hdr_st == ST_OK) ? aflag_next : 1'b0;
      tdata_next[4]   = (hdr_st == ST_OK) ? vflag_next : 1'b0;
    end
  end

  // Parser state registers; the final byte restarts the parser
  always_ff @(posedge clk) begin
    if (rst || (acc && s_tlast)) begin
      phase  <= PH_SIG;
      cnt    <= 24'd0;
      hextra <= 32'd0;
      prev   <= 32'd0;
      ttype  <= 8'd0;
      blen   <= 24'd0;
      tstamp <= 32'd0;
      sid    <= 24'd0;
      media  <= 8'd0;
      pkt    <= 8'd0;
      off    <= 24'd0;
      aflag  <= 1'b0;
      vflag  <= 1'b0;
    end else if (acc) begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      hextra <= hextra_next;
      prev   <= prev_next;
      ttype  <= ttype_next;
      blen   <= blen_next;
      tstamp <= tstamp_next;
      sid    <= sid_next;
      media  <= media_next;
      pkt    <= pkt_next;
      off    <= off_next;
      aflag  <= aflag_next;
      vflag  <= vflag_next;
    end
  end

  // Report register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc && (emit_hdr || emit_tag)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (emit_hdr || emit_tag)) begin
      m_tdata <= tdata_next;
      m_tuser <= emit_tag ? KIND_TAG : KIND_HEADER;
    end
  end

endmodule

FILE: dv/flv_report_checker.sv
// Report checker for the FLV tag stream parser: byte-level parser prediction and report compare.
`timescale 1ns / 1ps
module flv_report_checker
  import flvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte[7:0]
  input  logic               s_tlast,   // end_of_stream
  input  logic               m_tvalid,
  input  logic               m_tready,
  // status[2:0], has_audio[3], has_video[4], rec_type[12:5], data_size[36:13],
  // timestamp[68:37], prev_tag_size[100:69], media_header[108:101],
  // packet_type[116:109], composition_offset[140:117], zero fill[143:141]
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tuser,   // result_kind
  output int                 errors,
  output int                 pending
);

  // Media header limits
  localparam logic [3:0] AUDIO_FMT_RSVD_LO = 4'd12;
  localparam logic [3:0] AUDIO_FMT_RSVD_HI = 4'd13;
  localparam logic [3:0] FRAME_TYPE_MIN    = 4'd1;
  localparam logic [3:0] FRAME_TYPE_MAX    = 4'd5;
  localparam logic [3:0] CODEC_MIN         = 4'd1;
  localparam logic [7:0] AAC_PKT_MAX       = 8'd1;
  localparam logic [7:0] AVC_PKT_MAX       = 8'd2;

  localparam logic [7:0] FLV_SIG [3] = '{8'h46, 8'h4c, 8'h56};

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        audio;
    logic        video;
    logic [7:0]  rec_type;
    logic [23:0] data_size;
    logic [31:0] timestamp;
    logic [31:0] prev_size;
    logic [7:0]  media;
    logic [7:0]  pkt;
    logic [23:0] offset;
  } flv_report_t;

  flv_report_t reports_due[$];
  int fails = 0;
  int due_count = 0;

  assign errors  = fails;
  assign pending = due_count;

  // Parser state as seen from the byte stream
  logic [3:0]  phase;
  logic [23:0] count;
  logic [31:0] skip_left;
  logic [31:0] prev_word;
  logic [7:0]  ttype;
  logic [23:0] body_len;
  logic [31:0] stamp;
  logic [23:0] stream_id;
  logic [7:0]  media_b;
  logic [7:0]  pkt_b;
  logic [23:0] cto;
  logic        aflag;
  logic        vflag;

  task automatic clear_parser();
    phase = PH_SIG;
    count = '0; skip_left = '0; prev_word = '0; ttype = '0; body_len = '0;
    stamp = '0; stream_id = '0; media_b = '0; pkt_b = '0; cto = '0;
    aflag = 1'b0; vflag = 1'b0;
  endtask

  task automatic predict_header(input logic [2:0] st);
    flv_report_t r;
    r = '0;
    r.kind   = KIND_HEADER;
    r.status = st;
    if (st == ST_OK) begin
      r.audio = aflag;
      r.video = vflag;
    end
    reports_due.insert(reports_due.size(), r);
  endtask

  // Status and body fields of the current tag; count holds body bytes seen
  task automatic predict_tag(input bit complete);
    flv_report_t r;
    logic [7:0]  med;
    logic [7:0]  pkt;
    logic [23:0] off;
    logic [2:0]  st;
    logic [3:0]  hi;
    logic [3:0]  lo;
    med = '0; pkt = '0; off = '0;
    hi = media_b[7:4];
    lo = media_b[3:0];
    if (stream_id != '0) begin
      st = ST_STREAM_ID;
    end else if (ttype != TAG_AUDIO && ttype != TAG_VIDEO && ttype != TAG_SCRIPT) begin
      st = ST_BAD_TYPE;
    end else if (ttype == TAG_SCRIPT) begin
      st = complete ? ST_OK : ST_TRUNC;
    end else if (count < 1) begin
      st = complete ? ST_BAD_MEDIA : ST_TRUNC;
    end else begin
      med = media_b;
      if (ttype == TAG_AUDIO) begin
        if (hi == AUDIO_FMT_RSVD_LO || hi == AUDIO_FMT_RSVD_HI) st = ST_BAD_MEDIA;
        else if (hi != AUDIO_AAC) st = complete ? ST_OK : ST_TRUNC;
        else if (count < 2) st = complete ? ST_BAD_PKT : ST_TRUNC;
        else begin
          pkt = pkt_b;
          // AAC sequence header needs at least a 2-byte config
          if (pkt > AAC_PKT_MAX) st = ST_BAD_PKT;
          else if (pkt == 8'd0 && count < 4) st = complete ? ST_BAD_PKT : ST_TRUNC;
          else st = complete ? ST_OK : ST_TRUNC;
        end
      end else begin
        if (hi < FRAME_TYPE_MIN || hi > FRAME_TYPE_MAX || lo < CODEC_MIN || lo > VIDEO_AVC)
          st = ST_BAD_MEDIA;
        else if (lo != VIDEO_AVC) st = complete ? ST_OK : ST_TRUNC;
        else if (count < 2) st = complete ? ST_BAD_PKT : ST_TRUNC;
        else begin
          pkt = pkt_b;
          // composition offset occupies body bytes 2..4
          if (pkt > AVC_PKT_MAX) st = ST_BAD_PKT;
          else if (count < 5) st = complete ? ST_BAD_PKT : ST_TRUNC;
          else begin
            off = cto;
            st  = complete ? ST_OK : ST_TRUNC;
          end
        end
      end
      if (st == ST_BAD_MEDIA) pkt = '0;
    end
    r = '0;
    r.kind      = KIND_TAG;
    r.status    = st;
    r.audio     = aflag;
    r.video     = vflag;
    r.rec_type  = ttype;
    r.data_size = body_len;
    r.timestamp = stamp;
    r.prev_size = prev_word;
    r.media     = med;
    r.pkt       = pkt;
    r.offset    = off;
    reports_due.insert(reports_due.size(), r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    bit bad;
    bit emitted;
    bad = 1'b0;
    emitted = 1'b0;
    case (phase)
      PH_SIG: begin
        if (count < 3 && b == FLV_SIG[count]) begin
          count++;
          if (count == 3) begin
            phase = PH_VER;
            count = '0;
          end
        end else bad = 1'b1;
      end
      PH_VER: begin
        if (b == FLV_VERSION) phase = PH_FLAGS;
        else bad = 1'b1;
      end
      PH_FLAGS: begin
        if ((b & FLAGS_RSVD) != 8'd0) bad = 1'b1;
        else begin
          aflag = b[2];
          vflag = b[0];
          phase = PH_HSIZE;
          count = '0;
          skip_left = '0;
        end
      end
      PH_HSIZE: begin
        skip_left = {skip_left[23:0], b};
        count++;
        if (count >= 4) begin
          predict_header(ST_OK);
          emitted = 1'b1;
          skip_left = (skip_left > HDR_BASE_SIZE) ? skip_left - HDR_BASE_SIZE : '0;
          phase = (skip_left != '0) ? PH_HEXTRA : PH_PREV;
          count = '0;
        end
      end
      PH_HEXTRA: begin
        skip_left--;
        if (skip_left == '0) begin
          phase = PH_PREV;
          count = '0;
        end
      end
      PH_PREV: begin
        prev_word = {prev_word[23:0], b};
        count++;
        if (count >= 4) begin
          phase = PH_THDR;
          count = '0;
        end
      end
      PH_THDR: begin
        case (count)
          24'd0: begin
            ttype = b; body_len = '0; stamp = '0; stream_id = '0;
            media_b = '0; pkt_b = '0; cto = '0;
          end
          24'd1, 24'd2, 24'd3: body_len = {body_len[15:0], b};
          24'd4, 24'd5, 24'd6: stamp = {8'h00, stamp[15:0], b};
          24'd7: stamp[31:24] = b;
          default: stream_id = {stream_id[15:0], b};
        endcase
        count++;
        if (count >= 11) begin
          count = '0;
          if (body_len == '0) begin
            predict_tag(1'b1);
            emitted = 1'b1;
            phase = PH_PREV;
          end else phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (count == 0) media_b = b;
        else if (count == 1) pkt_b = b;
        else if (count <= 4) cto = {cto[15:0], b};
        count++;
        if (count >= body_len) begin
          predict_tag(1'b1);
          emitted = 1'b1;
          phase = PH_PREV;
          count = '0;
        end
      end
      default: ;
    endcase

    // broken file header: report it and drop bytes until end of stream
    if (bad) begin
      aflag = 1'b0;
      vflag = 1'b0;
      predict_header(ST_BAD_HDR);
      emitted = 1'b1;
      phase = PH_DEAD;
      count = '0;
    end

    if (eos) begin
      if (!emitted) begin
        if (phase <= PH_HSIZE) predict_header(ST_BAD_HDR);
        else if (phase == PH_BODY) predict_tag(1'b0);
      end
      clear_parser();
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      fails++;
    end
  endfunction

  task automatic check_report();
    flv_report_t want;
    if (reports_due.size() == 0) begin
      $display("%0t: unexpected report, expected none actual kind %0b tdata %0h",
               $time, m_tuser, m_tdata);
      fails++;
    end else begin
      want = reports_due.pop_front();
      check_field("result_kind", want.kind, m_tuser);
      check_field("status", want.status, m_tdata[2:0]);
      check_field("has_audio", want.audio, m_tdata[3]);
      check_field("has_video", want.video, m_tdata[4]);
      check_field("record type", want.rec_type, m_tdata[12:5]);
      check_field("data_size", want.data_size, m_tdata[36:13]);
      check_field("timestamp", want.timestamp, m_tdata[68:37]);
      check_field("prev_tag_size", want.prev_size, m_tdata[100:69]);
      check_field("media_header", want.media, m_tdata[108:101]);
      check_field("packet_type", want.pkt, m_tdata[116:109]);
      check_field("composition_offset", want.offset, m_tdata[140:117]);
      check_field("zero fill", '0, m_tdata[143:141]);
    end
  endtask

  // Watch both channels; input items first, a report never follows its byte in the same cycle
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      reports_due.delete();
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_report();
    end
    due_count <= reports_due.size();
  end

endmodule

FILE: dv/tb_flv_tag_stream_parser_core.sv
// Testbench top for the FLV tag stream parser: byte stream stimulus, sink, watchdog, verdict.
`timescale 1ns / 1ps
module tb_flv_tag_stream_parser_core
  import flvp_pkg::*;
();

  localparam int QUIET_LIMIT  = 2000;
  localparam int STREAM_ITEMS = 1400;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast  = 1'b0;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic m_tuser;
  logic [TDATA_W-1:0] m_tdata;

  int errors;
  int pending;
  int quiet = 0;
  int stream_bytes = 0;
  bit calm = 1'b0;

  logic [7:0] fq[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  flv_tag_stream_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  flv_report_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // Report sink with random stalls
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 30);
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Send the built file, final byte marked
  task automatic send_file();
    int i;
    stream_bytes += fq.size();
    for (i = 0; i < fq.size(); i++) send_byte(fq[i], i == fq.size() - 1);
    fq.delete();
  endtask

  // Hold the sender until every report has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Append one byte to the file being built
  task automatic put_byte(input logic [7:0] b);
    fq.insert(fq.size(), b);
  endtask

  task automatic put_word(input logic [31:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic put_hdr(input logic [7:0] flags, input logic [31:0] hsize);
    put_byte(8'h46);
    put_byte(8'h4c);
    put_byte(8'h56);
    put_byte(FLV_VERSION);
    put_byte(flags);
    put_word(hsize);
  endtask

  // Previous-size word plus the 11-byte tag header
  task automatic put_tag_hdr(input logic [31:0] prev, input logic [7:0] ttype,
                             input logic [23:0] size, input logic [31:0] ts,
                             input logic [23:0] sid);
    put_word(prev);
    put_byte(ttype);
    put_byte(size[23:16]);
    put_byte(size[15:8]);
    put_byte(size[7:0]);
    put_byte(ts[23:16]);
    put_byte(ts[15:8]);
    put_byte(ts[7:0]);
    put_byte(ts[31:24]);
    put_byte(sid[23:16]);
    put_byte(sid[15:8]);
    put_byte(sid[7:0]);
  endtask

  // Body with mostly sensible media and packet bytes
  task automatic put_media(input logic [7:0] ttype, input int size);
    int i;
    logic [7:0] v;
    for (i = 0; i < size; i++) begin
      v = 8'($urandom);
      if (i == 0 && ttype == TAG_AUDIO && $urandom_range(3) != 0)
        v = {AUDIO_AAC, 4'($urandom)};
      else if (i == 0 && ttype == TAG_VIDEO && $urandom_range(3) != 0)
        v = {4'($urandom_range(1, 5)), ($urandom_range(3) != 0) ? VIDEO_AVC : 4'($urandom)};
      else if (i == 1 && $urandom_range(3) != 0)
        v = 8'($urandom_range(2));
      put_byte(v);
    end
  endtask

  task automatic random_file();
    int ntag;
    int sz;
    int k;
    logic [7:0] flags;
    logic [7:0] tt;
    logic [31:0] hs;
    logic [23:0] sid;
    flags = ($urandom_range(9) == 0) ? 8'($urandom)
                                     : {5'b0, 1'($urandom), 1'b0, 1'($urandom)};
    case ($urandom_range(9))
      0:       hs = $urandom_range(0, 8);
      1:       hs = 9 + $urandom_range(1, 6);
      default: hs = 9;
    endcase
    put_hdr(flags, hs);
    if (hs > 9) put_rand(hs - 9);
    // occasional broken signature or version
    if ($urandom_range(11) == 0) begin
      k = $urandom_range(0, 3);
      fq[k] = fq[k] ^ (8'h01 << $urandom_range(7));
    end
    ntag = $urandom_range(1, 6);
    repeat (ntag) begin
      case ($urandom_range(9))
        0, 1, 2, 3: tt = TAG_AUDIO;
        4, 5, 6, 7: tt = TAG_VIDEO;
        8:          tt = TAG_SCRIPT;
        default:    tt = 8'($urandom);
      endcase
      sz  = ($urandom_range(19) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 9);
      sid = ($urandom_range(15) == 0) ? 24'($urandom) : 24'd0;
      put_tag_hdr($urandom, tt, 24'(sz), $urandom, sid);
      put_media(tt, sz);
    end
    // ending: trailing size word, cut short anywhere, or right after a body
    case ($urandom_range(3))
      0: put_word($urandom);
      1: begin
        k = $urandom_range(1, fq.size());
        while (fq.size() > k) void'(fq.pop_back());
      end
      default: ;
    endcase
    send_file();
  endtask

  task automatic directed();
    // bad signature, the rest ignored
    put_byte(8'h47);
    put_rand(3);
    send_file();
    // bad version
    put_hdr(8'h05, 9);
    fq[3] = 8'h02;
    send_file();
    // reserved flag bit set
    put_hdr(8'h02, 9);
    send_file();
    // stream ends inside the signature
    put_byte(8'h46);
    put_byte(8'h4c);
    send_file();
    // stream ends inside the header-size word
    put_hdr(8'h05, 9);
    repeat (3) void'(fq.pop_back());
    send_file();
    // stream ends on the final header byte
    put_hdr(8'h05, 9);
    send_file();
    // good file: AAC config, AVC with full offset, script, empty audio,
    // nonzero stream id, unknown type, trailing size word
    put_hdr(8'h05, 9);
    put_tag_hdr(32'd0, TAG_AUDIO, 24'd4, 32'd0, 24'd0);
    put_byte({AUDIO_AAC, 4'hf}); put_byte(8'h00); put_rand(2);
    put_tag_hdr(32'hffffffff, TAG_VIDEO, 24'd5, 32'hffffffff, 24'd0);
    put_byte(8'h17); put_byte(8'h01);
    put_byte(8'hff); put_byte(8'hff); put_byte(8'hff);
    put_tag_hdr(32'd15, TAG_SCRIPT, 24'd3, 32'd1, 24'd0);
    put_rand(3);
    put_tag_hdr(32'd14, TAG_AUDIO, 24'd0, 32'd0, 24'd0);
    put_tag_hdr(32'd0, 8'hff, 24'd2, 32'd0, 24'hffffff);
    put_rand(2);
    put_tag_hdr(32'd0, 8'h00, 24'd1, 32'd0, 24'd0);
    put_rand(1);
    put_word(32'h12345678);
    send_file();
    // extra header bytes, then media and packet errors, ending inside an AVC body
    put_hdr(8'h04, 12);
    put_rand(3);
    put_tag_hdr($urandom, TAG_AUDIO, 24'd2, $urandom, 24'd0);
    put_byte(8'hc3); put_byte(8'h00);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd1, $urandom, 24'd0);
    put_byte(8'h07);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd1, $urandom, 24'd0);
    put_byte(8'h10);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd2, $urandom, 24'd0);
    put_byte(8'h68); put_byte(8'h01);
    put_tag_hdr($urandom, TAG_AUDIO, 24'd2, $urandom, 24'd0);
    put_byte(8'ha0); put_byte(8'h02);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd5, $urandom, 24'd0);
    put_byte(8'h27); put_byte(8'h03); put_rand(3);
    put_tag_hdr($urandom, TAG_AUDIO, 24'd3, $urandom, 24'd0);
    put_byte(8'ha0); put_byte(8'h00); put_rand(1);
    put_tag_hdr($urandom, TAG_AUDIO, 24'd1, $urandom, 24'd0);
    put_byte(8'ha0);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd4, $urandom, 24'd0);
    put_byte(8'h17); put_byte(8'h01); put_rand(2);
    put_tag_hdr($urandom, TAG_VIDEO, 24'd20, $urandom, 24'd0);
    put_byte(8'h17); put_byte(8'h02);
    put_byte(8'h00); put_byte(8'h00); put_byte(8'h01); put_rand(1);
    send_file();
    // stream ends on the last tag header byte of a maximum-size body
    put_hdr(8'h01, 9);
    put_tag_hdr(32'd0, TAG_VIDEO, 24'hffffff, 32'd0, 24'd0);
    send_file();
    // maximum header-size word, stream ends while skipping
    put_hdr(8'h00, 32'hffffffff);
    put_rand(3);
    send_file();
    // stream ends inside a tag header
    put_hdr(8'h05, 9);
    put_word(32'd0);
    put_byte(TAG_AUDIO); put_byte(8'h00);
    send_file();
    // stream ends inside a size word
    put_hdr(8'h05, 9);
    put_byte(8'h00); put_byte(8'h00);
    send_file();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    drain();
    while (stream_bytes < STREAM_ITEMS) begin
      calm = (stream_bytes >= 500 && stream_bytes < 800);
      if ($urandom_range(9) == 0) begin
        put_rand($urandom_range(1, 12));
        send_file();
      end else begin
        random_file();
      end
      if ($urandom_range(19) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
